/* src/assert_macros.svh */
// Assertion macros shared by the list RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define TKL_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TKL_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

/* src/tkl_pkg.sv */
// Package for the top-k loudest list: shared constants and the cell flag type.
// No dependencies; used by tkl_cell and top_k_loudest_list.
package tkl_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int LEVEL_W         = 16;
    localparam int LIMIT_W         = 4;
    localparam int COUNT_OUT_W     = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd1;

    // Item modes
    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Compare result of one cell against the offered level
    typedef struct packed {
        logic gt;   // valid entry strictly above the offered level
        logic eq;   // valid entry equal to the offered level
    } cell_flags_t;

endpackage

/* src/top_k_loudest_list.sv */
// Top level of the top-k loudest list: a chain of tkl_cell slots plus count control.
// Depends on tkl_pkg, tkl_cell and assert_macros.svh.
//
// Usage
//   The block holds up to max_attended distinct levels (Q8.8 dB), sorted
//   from highest to lowest, capped at MAX_ENTRIES.
//   Input channel (in_valid/in_ready): mode 0 offers level, mode 1 clears.
//   Output channel (out_valid/out_ready): one item per input item, carrying
//   attending (offer now held) and held_count (entries after the item).
//   Result: registered, and it appears in the cycle after the input item is accepted.
//   Throughput: one item per cycle while the receiver keeps out_ready high;
//   every cell compares the broadcast level and shifts toward its neighbor
//   in the same cycle.
//   Stall: the result sits in an output register; while it waits, in_ready
//   stays high only if out_ready is high, so a stalled receiver holds one
//   item and then stalls the sender.
//   Configuration: a cfg_we pulse writes max_attended and empties the list.
//   Reset: the list is empty, max_attended is 1, no result is pending.
//   Cell contents are not reset; entries beyond the count are never used.
module top_k_loudest_list
#(
    parameter int MAX_ENTRIES = tkl_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [tkl_pkg::LIMIT_W-1:0]             cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    mode,
    input  logic signed [tkl_pkg::LEVEL_W-1:0]      level,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    attending,
    output logic [tkl_pkg::COUNT_OUT_W-1:0]         held_count
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Control registers
    logic [tkl_pkg::LIMIT_W-1:0]     max_reg;
    logic [tkl_pkg::LIMIT_W-1:0]     max_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_attending_reg;
    logic                            out_attending_next;
    logic [tkl_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic [tkl_pkg::COUNT_OUT_W-1:0] out_count_next;

    // Cell chain
    logic signed [tkl_pkg::LEVEL_W-1:0] cell_level [MAX_ENTRIES];
    logic signed [tkl_pkg::LEVEL_W-1:0] left_level [MAX_ENTRIES];
    logic                               left_gt    [MAX_ENTRIES];
    tkl_pkg::cell_flags_t               cell_flags [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]             cell_valid;
    logic [MAX_ENTRIES-1:0]             gt_vec;
    logic [MAX_ENTRIES-1:0]             eq_vec;

    // Item decision
    logic             accept;
    logic             is_offer;
    logic [CNT_W-1:0] lim_c;
    logic             dup_hit;
    logic             has_lower;
    logic             room;
    logic             do_insert;
    logic             item_attend;
    logic [CNT_W-1:0] item_count;

    assign accept   = in_valid && in_ready;
    assign is_offer = (mode == tkl_pkg::MODE_OFFER);
    assign in_ready = !out_valid_reg || out_ready;

    // Effective limit saturates at the number of cells.
    always_comb
    begin
        if (int'(max_reg) > MAX_ENTRIES)
        begin
            lim_c = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            lim_c = CNT_W'(max_reg);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            // The first count cells hold live entries.
            assign cell_valid[gi] = (int'(count_reg) > gi);
            assign gt_vec[gi]     = cell_flags[gi].gt;
            assign eq_vec[gi]     = cell_flags[gi].eq;

            if (gi == 0)
            begin : g_head
                // Head cell: nothing above it, so it takes the offer when it shifts.
                assign left_level[gi] = '0;
                assign left_gt[gi]    = 1'b1;
            end
            else
            begin : g_body
                assign left_level[gi] = cell_level[gi-1];
                assign left_gt[gi]    = cell_flags[gi-1].gt;
            end

            tkl_cell u_cell
            (
                .clk         (clk),
                .offer_level (level),
                .valid       (cell_valid[gi]),
                .insert_en   (accept && is_offer && do_insert),
                .left_level  (left_level[gi]),
                .left_gt     (left_gt[gi]),
                .level_q     (cell_level[gi]),
                .flags       (cell_flags[gi])
            );
        end
    endgenerate

    // A live entry not above the offer exists only if the offer beats the smallest
    // one (no duplicate case); then, if the list is full, the last entry drops off the end.
    always_comb
    begin
        dup_hit     = |eq_vec;
        has_lower   = |(cell_valid & ~gt_vec);
        room        = (count_reg < lim_c);
        do_insert   = !dup_hit && (lim_c != '0) && (room || has_lower);
        item_attend = is_offer && (dup_hit || do_insert);

        if (!is_offer)
        begin
            item_count = '0;
        end
        else if (do_insert && room)
        begin
            item_count = count_reg + CNT_W'(1);
        end
        else
        begin
            item_count = count_reg;
        end
    end

    // Next state of the control registers
    always_comb
    begin
        max_next           = max_reg;
        count_next         = count_reg;
        out_valid_next     = out_valid_reg;
        out_attending_next = out_attending_reg;
        out_count_next     = out_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            count_next         = item_count;
            out_valid_next     = 1'b1;
            out_attending_next = item_attend;
            out_count_next     = tkl_pkg::COUNT_OUT_W'(item_count);
        end

        // A limit write empties the list.
        if (cfg_we)
        begin
            max_next   = cfg_wdata;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= tkl_pkg::LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_reg       <= max_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_attending_reg <= out_attending_next;
        out_count_reg     <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign attending  = out_attending_reg;
    assign held_count = out_count_reg;

    // Checks
    `TKL_ASSERT(a_count_within_limit, clk, rst_n, count_reg <= lim_c, "list count above limit")
    `TKL_ASSERT(a_attend_nonempty, clk, rst_n, (out_valid_reg && out_attending_reg) |-> (out_count_reg != '0), "attending with empty list")
    `TKL_ASSERT(a_cfg_clears, clk, rst_n, cfg_we |=> (count_reg == '0), "limit write did not clear list")

    generate
        for (gi = 1; gi < MAX_ENTRIES; gi++)
        begin : g_order_chk
            `TKL_ASSERT(a_sorted, clk, rst_n, cell_valid[gi] |-> (cell_level[gi-1] > cell_level[gi]), "list not strictly descending")
        end
    endgenerate

endmodule

/* src/tkl_cell.sv */
// One slot of the sorted list: holds a level, compares it with the offered level,
// and on insert keeps, takes the new level, or takes its left neighbor. Uses tkl_pkg.
module tkl_cell
(
    input  logic                                clk,
    input  logic signed [tkl_pkg::LEVEL_W-1:0]  offer_level,
    input  logic                                valid,
    input  logic                                insert_en,
    input  logic signed [tkl_pkg::LEVEL_W-1:0]  left_level,
    input  logic                                left_gt,
    output logic signed [tkl_pkg::LEVEL_W-1:0]  level_q,
    output tkl_pkg::cell_flags_t                flags
);

    logic signed [tkl_pkg::LEVEL_W-1:0] level_reg;
    logic signed [tkl_pkg::LEVEL_W-1:0] level_next;

    always_comb
    begin
        flags.gt = valid && (level_reg > offer_level);
        flags.eq = valid && (level_reg == offer_level);
    end

    // Entries above the offer stay; the first slot not above takes the offer;
    // the rest shift one place down.
    always_comb
    begin
        level_next = level_reg;
        if (insert_en && !flags.gt)
        begin
            if (left_gt)
            begin
                level_next = offer_level;
            end
            else
            begin
                level_next = left_level;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    assign level_q = level_reg;

endmodule
